// File: hdl/rrefu_pkg.sv
// Shared constants and types for the round-robin envelope follower.
// No dependencies; every other file in hdl/ imports this package.
package rrefu_pkg;

	// Fraction bits carried by both filter states.
	localparam int FRAC_BITS = 8;

	// Configuration register indexes.
	localparam int CFG_ADDR_BITS = 2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_TICKS    = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_PEAK_COEFF    = 2'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_ATTACK_COEFF  = 2'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_RELEASE_COEFF = 2'd3;

	// Register widths and reset values.
	localparam int HOLD_BITS = 16;
	localparam logic [HOLD_BITS-1:0] HOLD_RESET = 16'd202;
	localparam int PEAK_COEFF_RESET    = 16734115;
	localparam int ATTACK_COEFF_RESET  = 16765569;
	localparam int RELEASE_COEFF_RESET = 16770227;

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = 1;
	localparam int QCNT_BITS   = 2;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// File: hdl/round_robin_envelope_follower_unit.sv
// Top level of the round-robin envelope follower: configuration registers,
// front part, queue and back part. Depends on rrefu_pkg, rrefu_front,
// rrefu_queue and rrefu_back.
//
//   Port group  Direction  Contents
//   s_axis      in         one sample per item
//   m_axis      out        env_smooth and env_peak per item
//   cfg         in         register writes, no read-back
//
// For each item the back part uses its one multiplier first for the peak
// smoother, then for the attack/release follower, each as multiply then add.
// The front part takes one sample at a time and passes the slot maximum via a
// two-entry queue, so a stalled output lets two more items in before s_axis
// stops; it takes new samples while the back part works on earlier ones.
// Reset clears all slots and filter states and loads the register defaults.
module round_robin_envelope_follower_unit #(
	parameter int SLOT_COUNT  = 4,
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_BITS  = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Fields from bit 0: sample.
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// Fields from bit 0: env_smooth, env_peak.
	output logic [((2*SAMPLE_BITS-2+7)/8)*8-1:0]  m_axis_tdata,
	input  logic                                  cfg_we,
	input  logic [rrefu_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [((COEFF_BITS > rrefu_pkg::HOLD_BITS) ? COEFF_BITS :
		rrefu_pkg::HOLD_BITS)-1:0]               cfg_data
);
	import rrefu_pkg::*;

	localparam int MAG_BITS = SAMPLE_BITS - 1;
	localparam int OUT_W    = ((2 * MAG_BITS + 7) / 8) * 8;

	logic [HOLD_BITS-1:0]  hold_ticks_q;
	logic [COEFF_BITS-1:0] peak_coeff_q;
	logic [COEFF_BITS-1:0] attack_coeff_q;
	logic [COEFF_BITS-1:0] release_coeff_q;

	fifo_stat_t          q_stat;
	logic                push;
	logic [MAG_BITS-1:0] push_data;
	logic                pop;
	logic [MAG_BITS-1:0] pop_data;
	logic [MAG_BITS-1:0] env_smooth;
	logic [MAG_BITS-1:0] env_peak;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q    <= HOLD_RESET;
			peak_coeff_q    <= COEFF_BITS'(PEAK_COEFF_RESET);
			attack_coeff_q  <= COEFF_BITS'(ATTACK_COEFF_RESET);
			release_coeff_q <= COEFF_BITS'(RELEASE_COEFF_RESET);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_HOLD_TICKS:    hold_ticks_q    <= cfg_data[HOLD_BITS-1:0];
				REG_PEAK_COEFF:    peak_coeff_q    <= cfg_data[COEFF_BITS-1:0];
				REG_ATTACK_COEFF:  attack_coeff_q  <= cfg_data[COEFF_BITS-1:0];
				REG_RELEASE_COEFF: release_coeff_q <= cfg_data[COEFF_BITS-1:0];
			endcase
		end
	end

	// Front part: rectifier, peak slots, hold timer and slot maximum.
	rrefu_front #(
		.SLOT_COUNT (SLOT_COUNT),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
		.hold_ticks(hold_ticks_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Queue of slot maxima.
	rrefu_queue #(
		.WIDTH(MAG_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.stat     (q_stat)
	);

	// Back part: both one-pole filters on a shared multiplier.
	rrefu_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEFF_BITS (COEFF_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_data       (pop_data),
		.pop          (pop),
		.peak_coeff   (peak_coeff_q),
		.attack_coeff (attack_coeff_q),
		.release_coeff(release_coeff_q),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.env_smooth   (env_smooth),
		.env_peak     (env_peak)
	);

	assign m_axis_tdata = OUT_W'({env_peak, env_smooth});

	// The back part never takes from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// The front part never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_stat.full)
		else $error("push into full queue");

	// Every accepted item produces exactly one push on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (push && !s_axis_tready))
		else $error("accepted item not pushed");

endmodule

// File: hdl/rrefu_front.sv
// Front part: accepts samples, rectifies them, keeps the round-robin peak
// slots and hold timer, and pushes the slot maximum into the queue.
// Depends on rrefu_pkg.
module rrefu_front #(
	parameter int SLOT_COUNT  = 4,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	input  logic [rrefu_pkg::HOLD_BITS-1:0]    hold_ticks,
	input  rrefu_pkg::fifo_stat_t              q_stat,
	output logic                               push,
	output logic [SAMPLE_BITS-2:0]             push_data
);
	import rrefu_pkg::*;

	localparam int MAG_BITS = SAMPLE_BITS - 1;
	localparam int IDX_BITS = $clog2(SLOT_COUNT);
	localparam int SLOT_P2  = 1 << IDX_BITS;

	logic [MAG_BITS-1:0]  slot_q [SLOT_P2];
	logic [IDX_BITS-1:0]  idx_q;
	logic [HOLD_BITS-1:0] hold_q;
	logic                 busy_q;

	logic                  accept;
	logic [SAMPLE_BITS-1:0] neg;
	logic [MAG_BITS-1:0]   mag;
	logic                  advance;
	logic [IDX_BITS-1:0]   next_idx;
	logic [MAG_BITS-1:0]   lvl [IDX_BITS+1][SLOT_P2];

	// One sample at a time; the maximum is pushed the cycle after accept.
	assign in_ready = !busy_q && !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = busy_q;

	// Rectify, saturating the most negative sample.
	always_comb begin
		neg = (~sample) + SAMPLE_BITS'(1);
		if (!sample[SAMPLE_BITS-1]) begin
			mag = sample[MAG_BITS-1:0];
		end else if (neg[SAMPLE_BITS-1]) begin
			mag = '1;
		end else begin
			mag = neg[MAG_BITS-1:0];
		end
	end

	// Hold timer decides whether the active slot moves on.
	assign advance  = !(hold_q < hold_ticks);
	assign next_idx = (idx_q == IDX_BITS'(SLOT_COUNT - 1)) ? '0 : idx_q + IDX_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			hold_q <= '0;
			for (int i = 0; i < SLOT_P2; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			busy_q <= accept;
			if (accept) begin
				if (advance) begin
					idx_q  <= next_idx;
					hold_q <= '0;
				end else begin
					hold_q <= hold_q + HOLD_BITS'(1);
				end
				for (int i = 0; i < SLOT_P2; i++) begin
					if (advance && next_idx == IDX_BITS'(i)) begin
						slot_q[i] <= '0;
					end else if (idx_q == IDX_BITS'(i) && mag > slot_q[i]) begin
						slot_q[i] <= mag;
					end
				end
			end
		end
	end

	// Pairwise maximum tree over the slots; unused padding slots stay zero.
	always_comb begin
		for (int i = 0; i < SLOT_P2; i++) begin
			lvl[0][i] = slot_q[i];
		end
		for (int l = 0; l < IDX_BITS; l++) begin
			for (int i = 0; i < SLOT_P2; i++) begin
				lvl[l+1][i] = '0;
			end
			for (int i = 0; i < (SLOT_P2 >> (l + 1)); i++) begin
				lvl[l+1][i] = (lvl[l][2*i] > lvl[l][2*i+1]) ? lvl[l][2*i] : lvl[l][2*i+1];
			end
		end
		push_data = lvl[IDX_BITS][0];
	end

endmodule

// File: hdl/rrefu_queue.sv
// Two-entry queue carrying slot maxima from the front to the back part.
// Depends on rrefu_pkg.
module rrefu_queue #(
	parameter int WIDTH = 23
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      push_data,
	input  logic                  pop,
	output logic [WIDTH-1:0]      pop_data,
	output rrefu_pkg::fifo_stat_t stat
);
	import rrefu_pkg::*;

	logic [WIDTH-1:0]     entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign stat.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = entry_q[rd_ptr_q];

	// Entries hold payload only.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

// File: hdl/rrefu_back.sv
// Back part: runs the peak smoother and the attack/release follower on one
// shared multiplier and holds the output register.
// Depends on rrefu_pkg.
module rrefu_back #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_BITS  = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rrefu_pkg::fifo_stat_t  q_stat,
	input  logic [SAMPLE_BITS-2:0] q_data,
	output logic                   pop,
	input  logic [COEFF_BITS-1:0]  peak_coeff,
	input  logic [COEFF_BITS-1:0]  attack_coeff,
	input  logic [COEFF_BITS-1:0]  release_coeff,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-2:0] env_smooth,
	output logic [SAMPLE_BITS-2:0] env_peak
);
	import rrefu_pkg::*;

	localparam int MAG_BITS   = SAMPLE_BITS - 1;
	localparam int LEVEL_BITS = MAG_BITS + FRAC_BITS;
	localparam int PROD_BITS  = LEVEL_BITS + COEFF_BITS;

	// Sequencer states.
	localparam logic [1:0] ST_MUL1 = 2'd0;
	localparam logic [1:0] ST_ACC1 = 2'd1;
	localparam logic [1:0] ST_MUL2 = 2'd2;
	localparam logic [1:0] ST_ACC2 = 2'd3;

	logic [1:0]            state_q;
	logic [LEVEL_BITS-1:0] peak_q;
	logic [LEVEL_BITS-1:0] smooth_q;
	logic [LEVEL_BITS-1:0] tgt_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic                  dir_q;
	logic                  out_valid_q;
	logic [MAG_BITS-1:0]   env_smooth_q;
	logic [MAG_BITS-1:0]   env_peak_q;

	logic [LEVEL_BITS-1:0] op_t;
	logic [LEVEL_BITS-1:0] op_old;
	logic [COEFF_BITS-1:0] op_c;
	logic                  op_ge;
	logic [LEVEL_BITS-1:0] op_diff;
	logic [PROD_BITS-1:0]  mul;
	logic [LEVEL_BITS-1:0] acc_t;
	logic [LEVEL_BITS-1:0] acc_q;
	logic                  acc_rem;
	logic [LEVEL_BITS-1:0] acc_new;
	logic                  out_free;

	assign out_valid  = out_valid_q;
	assign env_smooth = env_smooth_q;
	assign env_peak   = env_peak_q;
	assign out_free   = !out_valid_q || out_ready;
	assign pop        = (state_q == ST_MUL1) && !q_stat.empty;

	// Multiply step: operands of the peak smoother or of the follower.
	always_comb begin
		if (state_q == ST_MUL2) begin
			op_t   = peak_q;
			op_old = smooth_q;
			op_c   = (peak_q > smooth_q) ? attack_coeff : release_coeff;
		end else begin
			op_t   = {q_data, {FRAC_BITS{1'b0}}};
			op_old = peak_q;
			op_c   = peak_coeff;
		end
		op_ge   = (op_old >= op_t);
		op_diff = op_ge ? (op_old - op_t) : (op_t - op_old);
		mul     = PROD_BITS'(op_diff) * PROD_BITS'(op_c);
	end

	// Accumulate step: floor above the target, ceiling below it.
	always_comb begin
		acc_t   = (state_q == ST_ACC1) ? tgt_q : peak_q;
		acc_q   = prod_q[PROD_BITS-1:COEFF_BITS];
		acc_rem = |prod_q[COEFF_BITS-1:0];
		acc_new = dir_q ? (acc_t + acc_q) : (acc_t - acc_q - LEVEL_BITS'(acc_rem));
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MUL1: begin
				tgt_q  <= op_t;
				prod_q <= mul;
				dir_q  <= op_ge;
			end
			ST_MUL2: begin
				prod_q <= mul;
				dir_q  <= op_ge;
			end
			ST_ACC1: begin
			end
			ST_ACC2: begin
				if (out_free) begin
					env_smooth_q <= acc_new[LEVEL_BITS-1:FRAC_BITS];
					env_peak_q   <= peak_q[LEVEL_BITS-1:FRAC_BITS];
				end
			end
		endcase
	end

	// Sequencer, filter states and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_MUL1;
			peak_q      <= '0;
			smooth_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_MUL1: begin
					if (!q_stat.empty) begin
						state_q <= ST_ACC1;
					end
				end
				ST_ACC1: begin
					peak_q  <= acc_new;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					state_q <= ST_ACC2;
				end
				ST_ACC2: begin
					if (out_free) begin
						smooth_q    <= acc_new;
						out_valid_q <= 1'b1;
						state_q     <= ST_MUL1;
					end
				end
			endcase
		end
	end

endmodule
